// ----- src/wped_pkg.sv -----
package wped_pkg;

    // shared multiplier operand and product
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    typedef logic signed [MUL_W-1:0]  mul_op_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    typedef logic signed [15:0] sample_t;
    typedef logic        [15:0] power_t;
    typedef logic        [15:0] level_t;

    // dc blocker coefficients, unsigned with 30 fraction bits
    localparam logic [29:0] COEF_B0 = 30'd1073345117;
    localparam logic [29:0] COEF_P  = 30'd1072948409;

    // filter output format: 28 fraction bits
    localparam logic [28:0] Y_ONE      = 29'd268435456;
    localparam logic [63:0] ROUND_HALF = 64'd536870912;

    localparam logic signed [33:0] Y_MAX = 34'sd2147483647;
    localparam logic signed [33:0] Y_MIN = -34'sd2147483648;

    localparam logic [31:0] DECAY_RESET = 32'd4293395961;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } ring_ctrl_t;

endpackage

// ----- src/wped_mul.sv -----
module wped_mul (
    input  logic              clk,
    input  wped_pkg::mul_op_t op_a,
    input  wped_pkg::mul_op_t op_b,
    output wped_pkg::prod_t   prod
);
    import wped_pkg::*;

    prod_t prod_reg;

    // one signed multiply per cycle, product registered
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

// ----- src/wped_ring.sv -----
module wped_ring #(
    parameter int WINDOW_LEN = 512
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  wped_pkg::ring_ctrl_t ctrl,
    input  wped_pkg::power_t     wr_data,
    output wped_pkg::power_t     rd_data
);
    import wped_pkg::*;

    localparam int POS_W = $clog2(WINDOW_LEN);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_LEN - 1);

    power_t           mem [WINDOW_LEN];
    power_t           rd_reg;
    logic [POS_W-1:0] pos_reg;
    logic             full_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rd_reg <= mem[pos_reg];
        end
        if (ctrl.wr_en)
        begin
            mem[pos_reg] <= wr_data;
        end
    end

    // full flag: before the first wrap every slot still reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            full_reg <= 1'b0;
        end
        else if (ctrl.wr_en)
        begin
            if (pos_reg == POS_LAST)
            begin
                pos_reg  <= '0;
                full_reg <= 1'b1;
            end
            else
            begin
                pos_reg <= pos_reg + POS_W'(1);
            end
        end
    end

    assign rd_data = full_reg ? rd_reg : '0;

endmodule

// ----- src/windowed_power_envelope_detector.sv -----
// an accepted sample beat runs through the sequencer from S_MB0 to S_DONE and
// its result beat is then offered, later if the output register is still occupied
// when the result is ready; no new sample is taken until the sequencer is back in
// S_IDLE, as it runs all six multiplies of an item through one shared 33x33 multiplier
// reset: asynchronous active low, clears filter, window sum, envelope and ring
// position; decay factor returns to its default, no clearing pass is needed
module windowed_power_envelope_detector #(
    parameter int WINDOW_LEN = 512
) (
    input  logic              clk,
    input  logic              rst_n,
    // sample channel
    input  logic              in_valid,
    output logic              in_stall,
    input  wped_pkg::sample_t sample,
    // result channel
    output logic              out_valid,
    input  logic              out_stall,
    output wped_pkg::level_t  mean_square_level,
    output wped_pkg::level_t  envelope_level,
    // decay factor write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [31:0]       cfg_data
);
    import wped_pkg::*;

    localparam int POS_W = $clog2(WINDOW_LEN);
    // window sum never exceeds WINDOW_LEN * 65535
    localparam int SUM_W = POS_W + 16;
    // reciprocal for the divide by window length; quotient estimate is at
    // most one low since the sum stays far below 2^32
    localparam logic [63:0] RECIP_FULL = (64'd1 << 32) / 64'(WINDOW_LEN);
    localparam logic [SUM_W-1:0] LEN_SUM = SUM_W'(WINDOW_LEN);

    // sequencer codes
    localparam logic [3:0] S_IDLE = 4'd0;   // wait for a sample
    localparam logic [3:0] S_MB0  = 4'd1;   // b0 * (x - x1)
    localparam logic [3:0] S_MP   = 4'd2;   // p * y1
    localparam logic [3:0] S_ADD  = 4'd3;   // sum, round, saturate
    localparam logic [3:0] S_ABS  = 4'd4;   // magnitude and clip
    localparam logic [3:0] S_SQ   = 4'd5;   // a * a
    localparam logic [3:0] S_PWR  = 4'd6;   // scale to 0.16 power
    localparam logic [3:0] S_SUM  = 4'd7;   // running sum, ring write
    localparam logic [3:0] S_DIVM = 4'd8;   // sum * reciprocal
    localparam logic [3:0] S_DIVQ = 4'd9;   // quotient * window length
    localparam logic [3:0] S_DIVC = 4'd10;  // correct quotient, env * decay
    localparam logic [3:0] S_ENVU = 4'd11;  // envelope update
    localparam logic [3:0] S_DONE = 4'd12;  // hand result to output register

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // model state
    sample_t            prev_sample_reg;
    logic signed [31:0] prev_filtered_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [31:0]        env_reg;
    logic [31:0]        decay_reg;

    // per item working registers
    logic signed [16:0] diff_reg;
    logic signed [63:0] acc_reg;
    logic [28:0]        mag_reg;
    power_t             power_reg;
    logic [15:0]        quot_reg;
    level_t             mean_reg;

    // output register
    logic   out_valid_reg;
    level_t out_mean_reg;
    level_t out_env_reg;

    // shared multiplier
    mul_op_t op_a;
    mul_op_t op_b;
    prod_t   prod;

    ring_ctrl_t ring_ctrl;
    power_t     old_power;

    logic in_accept;
    logic out_accept;
    logic out_load;

    // combinational helpers
    logic signed [63:0] filt_sum;
    logic signed [33:0] filt_wide;
    logic signed [31:0] filt_sat;
    logic [32:0]        filt_abs;
    logic [32:0]        sq_val;
    logic [48:0]        sq_scaled;
    logic [SUM_W-1:0]   remainder;
    logic [16:0]        quot_fix;
    logic [31:0]        level_wide;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;
    // output slot is free when empty or being emptied this cycle
    assign out_load   = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign cfg_ready  = 1'b1;

    wped_mul u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    assign ring_ctrl.rd_en = in_accept;
    assign ring_ctrl.wr_en = (state_reg == S_SUM);

    wped_ring #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ring_ctrl),
        .wr_data (power_reg),
        .rd_data (old_power)
    );

    // operand select; the product is registered and appears in the next cycle
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            S_MB0:
            begin
                op_a = mul_op_t'({3'b000, COEF_B0});
                op_b = mul_op_t'({{16{diff_reg[16]}}, diff_reg});
            end
            S_MP:
            begin
                op_a = mul_op_t'({3'b000, COEF_P});
                op_b = mul_op_t'({prev_filtered_reg[31], prev_filtered_reg});
            end
            S_SQ:
            begin
                op_a = mul_op_t'({4'b0000, mag_reg});
                op_b = mul_op_t'({4'b0000, mag_reg});
            end
            S_DIVM:
            begin
                op_a = mul_op_t'(sum_reg);
                op_b = mul_op_t'(RECIP_FULL[32:0]);
            end
            S_DIVQ:
            begin
                op_a = mul_op_t'(prod[47:32]);
                op_b = mul_op_t'(WINDOW_LEN);
            end
            S_DIVC:
            begin
                op_a = mul_op_t'({1'b0, env_reg});
                op_b = mul_op_t'({1'b0, decay_reg});
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // filter output: round half up is a floor after adding half, folded
    // into acc_reg; saturation is a guard only
    always_comb
    begin
        filt_sum  = acc_reg + $signed(prod[63:0]);
        filt_wide = filt_sum[63:30];
        if (filt_wide > Y_MAX)
        begin
            filt_sat = 32'sh7fffffff;
        end
        else if (filt_wide < Y_MIN)
        begin
            filt_sat = -32'sh80000000;
        end
        else
        begin
            filt_sat = filt_wide[31:0];
        end
    end

    // magnitude, power scaling (sq * 65535 / 2^32 as a shift and subtract), quotient fix
    always_comb
    begin
        filt_abs   = prev_filtered_reg[31]
                   ? (33'd0 - 33'({prev_filtered_reg[31], prev_filtered_reg}))
                   : 33'({1'b0, prev_filtered_reg});
        sq_val     = prod[56:24];
        sq_scaled  = {sq_val, 16'h0000} - 49'(sq_val);
        remainder  = sum_reg - prod[SUM_W-1:0];
        quot_fix   = (remainder >= LEN_SUM) ? (17'(quot_reg) + 17'd1) : 17'(quot_reg);
        level_wide = {mean_reg, 16'h0000};
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_accept) state_next = S_MB0;
            S_MB0:  state_next = S_MP;
            S_MP:   state_next = S_ADD;
            S_ADD:  state_next = S_ABS;
            S_ABS:  state_next = S_SQ;
            S_SQ:   state_next = S_PWR;
            S_PWR:  state_next = S_SUM;
            S_SUM:  state_next = S_DIVM;
            S_DIVM: state_next = S_DIVQ;
            S_DIVQ: state_next = S_DIVC;
            S_DIVC: state_next = S_ENVU;
            S_ENVU: state_next = S_DONE;
            S_DONE: if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control and model state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            prev_sample_reg   <= '0;
            prev_filtered_reg <= '0;
            sum_reg           <= '0;
            env_reg           <= '0;
            decay_reg         <= DECAY_RESET;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                decay_reg <= cfg_data;
            end

            if (in_accept)
            begin
                prev_sample_reg <= sample;
            end

            if (state_reg == S_ADD)
            begin
                prev_filtered_reg <= filt_sat;
            end

            // running window sum: add newest, drop the one it overwrites
            if (state_reg == S_SUM)
            begin
                sum_reg <= sum_reg + SUM_W'(power_reg) - SUM_W'(old_power);
            end

            // jump up to a higher level, otherwise decay
            if (state_reg == S_ENVU)
            begin
                if (level_wide > env_reg)
                begin
                    env_reg <= level_wide;
                end
                else
                begin
                    env_reg <= prod[63:32];
                end
            end

            if (out_accept)
            begin
                out_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // per item datapath, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            diff_reg <= 17'(sample) - 17'(prev_sample_reg);
        end

        // b0 * d scaled to 2^-43, plus rounding half
        if (state_reg == S_MP)
        begin
            acc_reg <= ($signed(prod[63:0]) <<< 13) + $signed(ROUND_HALF);
        end

        if (state_reg == S_ABS)
        begin
            mag_reg <= (filt_abs > 33'(Y_ONE)) ? Y_ONE : filt_abs[28:0];
        end

        if (state_reg == S_PWR)
        begin
            power_reg <= sq_scaled[47:32];
        end

        if (state_reg == S_DIVQ)
        begin
            quot_reg <= prod[47:32];
        end

        // mean cannot pass full scale, clamp kept as a guard
        if (state_reg == S_DIVC)
        begin
            mean_reg <= quot_fix[16] ? 16'hffff : quot_fix[15:0];
        end

        if (out_load)
        begin
            out_mean_reg <= mean_reg;
            out_env_reg  <= env_reg[31:16];
        end
    end

    assign out_valid         = out_valid_reg;
    assign mean_square_level = out_mean_reg;
    assign envelope_level    = out_env_reg;

endmodule

// ----- tb/tb_windowed_power_envelope_detector.sv -----
`timescale 1ns / 1ps

module tb_windowed_power_envelope_detector;

    import wped_pkg::*;

    // ring length of the averaging window
    localparam int WINDOW = 512;

    // decay factor that the block comes out of reset with
    localparam logic [31:0] DEFAULT_DECAY = 32'd4293395961;

    // dc blocker in 30-bit fixed point, filter output with 28 fraction bits
    localparam longint DC_B0     = 64'd1073345117;
    localparam longint DC_POLE   = 64'd1072948409;
    localparam longint HALF_LSB  = 64'd536870912;
    localparam longint FILT_ONE  = 64'd268435456;
    localparam longint FILT_MAX  = 64'd2147483647;
    localparam longint FILT_MIN  = -64'sd2147483648;

    // run limit, several times the slowest legal run
    localparam int CYCLE_LIMIT = 600000;

    // a result beat as two level fields
    typedef struct packed {
        level_t mean_square;
        level_t envelope;
    } levels_t;

    // shapes of sample sequences for the random part
    typedef enum int {
        PAT_NOISE,
        PAT_SILENCE,
        PAT_DC,
        PAT_TONE,
        PAT_FULL_SCALE,
        PAT_BURST
    } pattern_e;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    sample_t     sample = '0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    level_t      mean_square_level;
    level_t      envelope_level;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;

    // shared run state
    bit          idling_on = 1'b1;
    int          error_count = 0;
    int          cycle_count = 0;
    int          stall_left = 0;

    // levels still owed by the block, oldest first
    levels_t     expected_levels[$];

    // predictor state: filter memory, power ring, envelope, decay register
    logic [31:0] decay_m;
    sample_t     prev_sample_m;
    int          prev_filtered_m;
    logic [15:0] power_ring[WINDOW];
    int          ring_pos;
    logic [31:0] ring_sum;
    logic [31:0] envelope_m;

    windowed_power_envelope_detector #(
        .WINDOW_LEN(WINDOW)
    ) dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .sample            (sample),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .mean_square_level (mean_square_level),
        .envelope_level    (envelope_level),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data)
    );

    always #5 clk = ~clk;

    // hard stop if the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("windowed_power_envelope_detector test failed");
            $finish;
        end
    end

    // receiver backpressure: short random stalls plus rare long holds
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (idling_on && $urandom_range(0, 999) < 2)
        begin
            stall_left <= $urandom_range(1, 24);
            out_stall  <= 1'b1;
        end
        else
        begin
            out_stall <= idling_on && ($urandom_range(0, 99) < 5);
        end
    end

    // compare every accepted result beat against the oldest prediction
    always @(posedge clk)
    begin
        levels_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_levels.size() == 0)
            begin
                $error("result beat with no sample pending: mean_square_level %0d "
                       , mean_square_level, "envelope_level %0d", envelope_level);
                error_count++;
            end
            else
            begin
                want = expected_levels.pop_front();
                if (mean_square_level !== want.mean_square)
                begin
                    $error("mean_square_level expected %0d actual %0d",
                           want.mean_square, mean_square_level);
                    error_count++;
                end
                if (envelope_level !== want.envelope)
                begin
                    $error("envelope_level expected %0d actual %0d",
                           want.envelope, envelope_level);
                    error_count++;
                end
            end
        end
    end

    // predictor back to its power-up state
    task automatic clear_levels_model();
        decay_m         = DEFAULT_DECAY;
        prev_sample_m   = '0;
        prev_filtered_m = 0;
        for (int i = 0; i < WINDOW; i++)
            power_ring[i] = '0;
        ring_pos   = 0;
        ring_sum   = '0;
        envelope_m = '0;
    endtask

    // one sample through dc blocker, squarer, window mean and peak envelope
    function automatic levels_t compute_levels(input sample_t x);
        longint      diff;
        longint      acc;
        longint      filt;
        longint      mag;
        longint      sq;
        logic [15:0] power;
        logic [31:0] mean;
        logic [31:0] level;
        logic [63:0] scaled;
        levels_t     res;

        // y = b0*(x - x1) + p*y1, rounded half up to 28 fraction bits
        diff = longint'(x) - longint'(prev_sample_m);
        acc  = DC_B0 * diff * 8192 + DC_POLE * longint'(prev_filtered_m);
        if (acc >= 0)
            filt = (acc + HALF_LSB) >>> 30;
        else
            filt = -(((-acc) + HALF_LSB - 1) >>> 30);
        if (filt > FILT_MAX)
            filt = FILT_MAX;
        if (filt < FILT_MIN)
            filt = FILT_MIN;
        prev_sample_m   = x;
        prev_filtered_m = int'(filt);

        // magnitude clipped to full scale, squared into 0.16 power
        mag = (filt < 0) ? -filt : filt;
        if (mag > FILT_ONE)
            mag = FILT_ONE;
        sq    = (mag * mag) >> 24;
        power = 16'((sq * 65535) >> 32);

        // running window sum over the power ring
        ring_sum = ring_sum + 32'(power) - 32'(power_ring[ring_pos]);
        power_ring[ring_pos] = power;
        ring_pos = (ring_pos + 1) % WINDOW;

        mean = ring_sum / WINDOW;
        if (mean > 32'd65535)
            mean = 32'd65535;

        // jump up to a higher level, otherwise decay multiplicatively
        level = mean << 16;
        if (level > envelope_m)
        begin
            envelope_m = level;
        end
        else
        begin
            scaled     = 64'(envelope_m) * 64'(decay_m);
            envelope_m = scaled[63:32];
        end

        res.mean_square = mean[15:0];
        res.envelope    = envelope_m[31:16];
        return res;
    endfunction

    // one sample beat, with an occasional random gap in front of it
    task automatic send_sample(input sample_t value);
        if (idling_on && $urandom_range(0, 99) < 10)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_levels.push_back(compute_levels(value));
    endtask

    // hold the sample channel until every owed result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_levels.size() != 0)
            @(posedge clk);
    endtask

    // decay factor write, only with the block idle
    task automatic write_decay(input logic [31:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        decay_m = value;
    endtask

    // a run of samples of one shape, random amplitude, period and offset
    task automatic play_pattern(input pattern_e kind, input int count);
        int unsigned amp;
        int unsigned period;
        logic [15:0] level_hi;
        logic [15:0] dc_value;
        logic [15:0] s;
        amp      = $urandom_range(0, 32767);
        period   = $urandom_range(2, 64);
        level_hi = amp[15:0];
        dc_value = 16'($urandom);
        for (int i = 0; i < count; i++)
        begin
            case (kind)
                PAT_NOISE:      s = 16'($urandom);
                PAT_SILENCE:    s = '0;
                PAT_DC:         s = dc_value;
                // square wave, low half is the bitwise complement of the high
                PAT_TONE:       s = ((i % period) < period / 2) ? level_hi : ~level_hi;
                PAT_FULL_SCALE: s = i[0] ? 16'h8000 : 16'h7fff;
                default:        s = 16'($urandom_range(0, 2 * amp) - amp);
            endcase
            send_sample(s);
        end
    endtask

    // mostly tones and bursts, some silence, dc steps and full-scale squares, some raw noise
    task automatic play_random(input int total);
        int       left;
        int       len;
        int       pick;
        pattern_e kind;
        left = total;
        while (left > 0)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
                kind = PAT_NOISE;
            else if (pick < 25)
                kind = PAT_SILENCE;
            else if (pick < 35)
                kind = PAT_DC;
            else if (pick < 70)
                kind = PAT_TONE;
            else if (pick < 80)
                kind = PAT_FULL_SCALE;
            else
                kind = PAT_BURST;
            len = $urandom_range(8, 128);
            if (len > left)
                len = left;
            play_pattern(kind, len);
            left -= len;
        end
    endtask

    // field extremes, largest steps, dc steps and sign flips at the reset decay
    task automatic test_directed_extremes();
        sample_t seq[$];
        seq = '{16'sh0000, 16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000,
                16'sh0000, -16'sh0001, 16'sh0001, 16'sh5555, -16'sh5556,
                16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                -16'sh8000, -16'sh8000, -16'sh8000,
                16'sh0000, 16'sh0000, 16'sh0000,
                16'sh4000, -16'sh4000};
        foreach (seq[i])
            send_sample(seq[i]);
    endtask

    // full-scale square fills the whole window so the mean pins at full scale,
    // then silence lets the envelope fall away
    task automatic test_full_scale_window();
        play_pattern(PAT_FULL_SCALE, WINDOW + 20);
        play_pattern(PAT_SILENCE, 40);
    endtask

    // zero decay: envelope drops to zero on every sample that does not raise it
    task automatic test_zero_decay();
        write_decay(32'h0000_0000);
        play_random(250);
    endtask

    // largest decay, run back to back with no gaps on either side
    task automatic test_unity_decay();
        write_decay(32'hffff_ffff);
        idling_on = 1'b0;
        play_random(250);
        idling_on = 1'b1;
    endtask

    // random decay settings, one pause mid-phase until the block runs dry
    task automatic test_random_decay();
        logic [31:0] value;
        for (int round = 0; round < 4; round++)
        begin
            case (round)
                0:       value = 32'($urandom_range(0, 32'hffff));
                1:       value = 32'hfff0_0000 | 32'($urandom_range(0, 32'hf_ffff));
                default: value = $urandom;
            endcase
            write_decay(value);
            play_random(75);
            drain_results();
            play_random(75);
        end
    endtask

    // back to the power-up decay factor
    task automatic test_default_decay_restore();
        write_decay(DEFAULT_DECAY);
        play_random(200);
    endtask

    initial
    begin
        clear_levels_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_full_scale_window();
        test_zero_decay();
        test_unity_decay();
        test_random_decay();
        test_default_decay_restore();

        // let the last results out, then watch for anything stray
        drain_results();
        repeat (20) @(posedge clk);

        if (error_count == 0)
            $display("windowed_power_envelope_detector test passed");
        else
            $display("windowed_power_envelope_detector test failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/wped_pkg.sv
src/wped_mul.sv
src/wped_ring.sv
src/windowed_power_envelope_detector.sv
tb/tb_windowed_power_envelope_detector.sv
